// ----- hw/rtl/meps_pkg.sv -----
// Shared types, constants and helpers for the Mandelbrot escape-time pixel core.
`default_nettype none

package meps_pkg;

  localparam int PIX_W     = 12;  // signed pixel offset
  localparam int DIM_W     = 13;  // image dimension register
  localparam int INT_W     = 8;   // output intensity
  localparam int Z_W       = 32;  // fixed-point word for c and z
  localparam int Z2_W      = 2 * Z_W;
  localparam int CFG_IDX_W = 4;

  localparam int MAX_ITER_DEF  = 164;
  localparam int FRAC_BITS_DEF = 28;
  localparam int DIV_W_DEF     = PIX_W + 2 + FRAC_BITS_DEF;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IDX = CFG_IDX_W'(1);
  localparam logic [DIM_W-1:0]     DIM_RESET      = DIM_W'(2000);

  localparam logic TAG_X = 1'b0;
  localparam logic TAG_Y = 1'b1;

  localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

  // control that rides along the divider chain
  typedef struct packed {
    logic valid;
    logic tag;   // TAG_X or TAG_Y
    logic neg;   // sign of the dividend
  } div_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DIV,
    ST_ITER
  } meps_state_t;

  typedef enum logic [1:0] {
    IT_IDLE,
    IT_MUL,
    IT_UPD
  } meps_it_state_t;

  // clamp a wide signed value into the Z_W-bit signed range
  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [Z2_W-1:0] v);
    if (v > Z2_W'(Z_MAX)) begin
      return Z_MAX;
    end else if (v < Z2_W'(Z_MIN)) begin
      return Z_MIN;
    end else begin
      return Z_W'(v);
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mandelbrot_escape_pixel_core.sv -----
// Top level of the Mandelbrot escape-time pixel core.
//
//   channel | ports                                    | transfer
//   --------+------------------------------------------+------------------------------
//   input   | start, busy, in_pix_x, in_pix_y          | edge with start && !busy
//   result  | out_strobe, out_intensity                | edge ending the strobe cycle
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data| edge with cfg_valid && cfg_ready
//
// One item at a time. An item runs through DIV_W = 14 + FRAC_BITS divider cells and then
// through p multiply/update passes, with p = escape count + 1, or MAX_ITER when the point
// never escapes; the result strobe follows the last pass.
// The escape loop (one 32x32 product stage plus one update stage per step) sets the rate.
// busy drops at the same edge the strobe rises, so the next item may start there.
// Reset is synchronous, active low; config registers come up at 2000.
// The result strobe is one cycle wide and cannot be stalled by the receiver.
`default_nettype none

module mandelbrot_escape_pixel_core #(
  parameter int MAX_ITER  = meps_pkg::MAX_ITER_DEF,
  parameter int FRAC_BITS = meps_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [meps_pkg::PIX_W-1:0]    in_pix_x,
  input  logic signed [meps_pkg::PIX_W-1:0]    in_pix_y,
  output logic                                 out_strobe,
  output logic [meps_pkg::INT_W-1:0]           out_intensity,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [meps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [meps_pkg::DIM_W-1:0]           cfg_data
);
  import meps_pkg::*;

  // divider word: |pix| followed by FRAC_BITS+2 zeros, i.e. |pix| * 4 * 2^FRAC_BITS
  localparam int DIV_W = PIX_W + 2 + FRAC_BITS;
  localparam int QX_W  = (DIV_W > Z_W + 1) ? DIV_W : Z_W + 1;
  localparam int CNT_W = $clog2(MAX_ITER + 1);

  // count * 255 / MAX_ITER by reciprocal; exact since count*255 < 2^16, MAX_ITER < 2^8
  localparam int SCL_W = 2 * INT_W;
  localparam int RCP_K = 3 * INT_W;
  localparam int RCP_W = RCP_K + 1;
  localparam int PRD_W = SCL_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP = RCP_W'((2**RCP_K + MAX_ITER - 1) / MAX_ITER);

  localparam logic [QX_W-1:0] POS_LIM = QX_W'((64'd1 << (Z_W - 1)) - 64'd1);
  localparam logic [QX_W-1:0] NEG_LIM = QX_W'(64'd1 << (Z_W - 1));

  meps_state_t             state_r, state_nxt;
  logic [DIM_W-1:0]        width_pixels_r, height_pixels_r;
  logic signed [PIX_W-1:0] pix_y_r;
  logic signed [Z_W-1:0]   cr_r;
  logic                    out_strobe_r;
  logic [INT_W-1:0]        out_intensity_r;

  // divider feed
  div_ctl_t                chain_in_ctl, chain_out_ctl;
  logic [DIV_W-1:0]        chain_in_word, chain_out_word;
  logic [DIM_W-1:0]        chain_in_den;
  logic signed [PIX_W-1:0] pix_sel;
  logic [DIM_W-1:0]        dim_sel;
  logic [PIX_W-1:0]        pix_mag;

  // quotient to c
  logic [QX_W-1:0]         qx;
  logic [Z_W-1:0]          q_lo;
  logic signed [Z_W-1:0]   c_map;

  // iteration unit
  logic                    it_go, it_done;
  logic [CNT_W-1:0]        it_count;

  // scaling
  logic [SCL_W-1:0]        scaled;
  logic [PRD_W-1:0]        prod;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_pixels_r  <= DIM_RESET;
      height_pixels_r <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH_IDX:  width_pixels_r  <= cfg_data;
        CFG_HEIGHT_IDX: height_pixels_r <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_FEED;
      ST_FEED: state_nxt = ST_DIV;
      ST_DIV:  if (chain_out_ctl.valid && (chain_out_ctl.tag == TAG_Y)) state_nxt = ST_ITER;
      ST_ITER: if (it_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // x enters the chain on the accept edge, y on the next one
  always_comb begin
    chain_in_ctl = '0;
    pix_sel      = in_pix_x;
    dim_sel      = width_pixels_r;
    it_go        = 1'b0;
    busy         = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          chain_in_ctl.valid = 1'b1;
          chain_in_ctl.tag   = TAG_X;
        end
      end
      ST_FEED: begin
        chain_in_ctl.valid = 1'b1;
        chain_in_ctl.tag   = TAG_Y;
        pix_sel            = pix_y_r;
        dim_sel            = height_pixels_r;
      end
      ST_DIV: begin
        it_go = chain_out_ctl.valid && (chain_out_ctl.tag == TAG_Y);
      end
      default: ;
    endcase
    chain_in_ctl.neg = pix_sel[PIX_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      pix_y_r <= in_pix_y;
    end
  end

  // ---------------------------------------------------------------- c mapping
  // magnitude of -2048 is 2048, still fits 12 unsigned bits
  assign pix_mag       = pix_sel[PIX_W-1] ? PIX_W'(~pix_sel + PIX_W'(1)) : pix_sel;
  assign chain_in_word = {pix_mag, {(FRAC_BITS + 2){1'b0}}};
  assign chain_in_den  = (dim_sel == '0) ? DIM_W'(1) : dim_sel;  // zero width or height acts as 1

  meps_div_chain #(
    .WORD_W (DIV_W)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (chain_in_ctl),
    .in_word  (chain_in_word),
    .in_den   (chain_in_den),
    .out_ctl  (chain_out_ctl),
    .out_word (chain_out_word)
  );

  // truncating quotient, sign restored, clamped to the 32-bit range
  always_comb begin
    qx   = QX_W'(chain_out_word);
    q_lo = qx[Z_W-1:0];
    if (chain_out_ctl.neg) begin
      c_map = (qx > NEG_LIM) ? Z_MIN : $signed(Z_W'(~q_lo + Z_W'(1)));
    end else begin
      c_map = (qx > POS_LIM) ? Z_MAX : $signed(q_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (chain_out_ctl.valid && (chain_out_ctl.tag == TAG_X)) begin
      cr_r <= c_map;
    end
  end

  // ---------------------------------------------------------------- iteration
  meps_iter #(
    .MAX_ITER  (MAX_ITER),
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (it_go),
    .c_re  (cr_r),
    .c_im  (c_map),
    .done  (it_done),
    .count (it_count)
  );

  // ---------------------------------------------------------------- result
  assign scaled = (SCL_W'(it_count) << INT_W) - SCL_W'(it_count);  // count * 255
  assign prod   = PRD_W'(scaled) * PRD_W'(RCP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= it_done;
    end
  end

  always_ff @(posedge clk) begin
    if (it_done) begin
      out_intensity_r <= prod[RCP_K+INT_W-1:RCP_K];
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_intensity = out_intensity_r;

endmodule

`default_nettype wire

// ----- hw/rtl/meps_div_cell.sv -----
// One restoring-division cell: one quotient bit per cell, registered.
`default_nettype none

module meps_div_cell #(
  parameter int WORD_W = meps_pkg::DIV_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  meps_pkg::div_ctl_t         in_ctl,
  input  logic [meps_pkg::DIM_W-1:0] in_rem,
  input  logic [WORD_W-1:0]          in_word,
  input  logic [meps_pkg::DIM_W-1:0] in_den,
  output meps_pkg::div_ctl_t         out_ctl,
  output logic [meps_pkg::DIM_W-1:0] out_rem,
  output logic [WORD_W-1:0]          out_word,
  output logic [meps_pkg::DIM_W-1:0] out_den
);
  import meps_pkg::*;

  div_ctl_t             ctl_r;
  logic [DIM_W-1:0]     rem_r, rem_nxt;
  logic [WORD_W-1:0]    word_r, word_nxt;
  logic [DIM_W-1:0]     den_r;
  logic [DIM_W:0]       trial;
  logic                 fits;

  // word shifts left: dividend bits leave at the top, quotient bits enter below
  always_comb begin
    trial    = {in_rem, in_word[WORD_W-1]};
    fits     = (trial >= {1'b0, in_den});
    rem_nxt  = fits ? DIM_W'(trial - {1'b0, in_den}) : trial[DIM_W-1:0];
    word_nxt = {in_word[WORD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    word_r <= word_nxt;
    den_r  <= in_den;
  end

  assign out_ctl  = ctl_r;
  assign out_rem  = rem_r;
  assign out_word = word_r;
  assign out_den  = den_r;

endmodule

`default_nettype wire

// ----- hw/rtl/meps_div_chain.sv -----
// Row of registered division cells; the unsigned quotient comes out of the last one.
`default_nettype none

module meps_div_chain #(
  parameter int WORD_W = meps_pkg::DIV_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  meps_pkg::div_ctl_t         in_ctl,
  input  logic [WORD_W-1:0]          in_word,
  input  logic [meps_pkg::DIM_W-1:0] in_den,
  output meps_pkg::div_ctl_t         out_ctl,
  output logic [WORD_W-1:0]          out_word
);
  import meps_pkg::*;

  div_ctl_t          ctl  [0:WORD_W];
  logic [DIM_W-1:0]  rem  [0:WORD_W];
  logic [WORD_W-1:0] word [0:WORD_W];
  logic [DIM_W-1:0]  den  [0:WORD_W];

  assign ctl[0]  = in_ctl;
  assign rem[0]  = '0;
  assign word[0] = in_word;
  assign den[0]  = in_den;

  for (genvar k = 0; k < WORD_W; k++) begin : g_cell
    meps_div_cell #(
      .WORD_W (WORD_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_ctl   (ctl[k]),
      .in_rem   (rem[k]),
      .in_word  (word[k]),
      .in_den   (den[k]),
      .out_ctl  (ctl[k+1]),
      .out_rem  (rem[k+1]),
      .out_word (word[k+1]),
      .out_den  (den[k+1])
    );
  end

  assign out_ctl  = ctl[WORD_W];
  assign out_word = word[WORD_W];

endmodule

`default_nettype wire

// ----- hw/rtl/meps_iter.sv -----
// Escape-time iteration unit: z = z*z + c, each step a multiply state followed by an update state.
`default_nettype none

module meps_iter #(
  parameter int MAX_ITER  = meps_pkg::MAX_ITER_DEF,
  parameter int FRAC_BITS = meps_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic signed [meps_pkg::Z_W-1:0]   c_re,
  input  logic signed [meps_pkg::Z_W-1:0]   c_im,
  output logic                              done,
  output logic [$clog2(MAX_ITER+1)-1:0]     count
);
  import meps_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITER + 1);
  localparam int SUM_W = Z2_W + 1;
  localparam logic [SUM_W-1:0] ESC_LIM  = SUM_W'(1) << (2 * FRAC_BITS + 2);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_ITER - 1);

  meps_it_state_t          st_r, st_nxt;
  logic signed [Z_W-1:0]   zr_r, zi_r, cr_r, ci_r;
  logic signed [Z2_W-1:0]  rr_r, ii_r, ri_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    done_r, done_nxt;
  logic                    esc, last;
  logic signed [Z2_W-1:0]  diff, nr, ni;

  always_comb begin
    esc  = (({1'b0, rr_r} + {1'b0, ii_r}) >= ESC_LIM);
    last = (cnt_r == LAST_CNT);
    diff = rr_r - ii_r;
    nr   = (diff >>> FRAC_BITS) + Z2_W'(cr_r);
    ni   = (ri_r >>> (FRAC_BITS - 1)) + Z2_W'(ci_r);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      IT_IDLE: if (go) st_nxt = IT_MUL;
      IT_MUL:  st_nxt = IT_UPD;
      IT_UPD:  st_nxt = (esc || last) ? IT_IDLE : IT_MUL;
      default: st_nxt = IT_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_nxt = 1'b0;
    case (st_r)
      IT_UPD:  done_nxt = esc || last;
      default: done_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= IT_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      IT_IDLE: begin
        if (go) begin
          zr_r  <= '0;
          zi_r  <= '0;
          cnt_r <= '0;
          cr_r  <= c_re;
          ci_r  <= c_im;
        end
      end
      IT_MUL: begin
        rr_r <= Z2_W'(zr_r) * Z2_W'(zr_r);
        ii_r <= Z2_W'(zi_r) * Z2_W'(zi_r);
        ri_r <= Z2_W'(zr_r) * Z2_W'(zi_r);
      end
      IT_UPD: begin
        if (!esc) begin
          zr_r  <= sat_z(nr);
          zi_r  <= sat_z(ni);
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign done  = done_r;
  assign count = cnt_r;

endmodule

`default_nettype wire

// ----- hw/rtl/meps_checker.sv -----
// Port-level checks for the escape-time pixel core, bound to the top level.
`default_nettype none

module meps_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  // an accepted item keeps the core busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("core not busy after accepting an item");

  // a result strobe lasts one cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  // the result shows only once the item has retired
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while still busy");

  // every finished item produces its result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_strobe)
    else $error("item finished without a result");

endmodule

bind mandelbrot_escape_pixel_core meps_checker u_meps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe)
);

`default_nettype wire
